[sv/integer_alu_with_compare_top_defines.svh]
// Assertion macros shared by the ALU RTL.
`ifndef INTEGER_ALU_WITH_COMPARE_TOP_DEFINES_SVH
`define INTEGER_ALU_WITH_COMPARE_TOP_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define IALU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define IALU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/ialu_pkg.sv]
// Types, command codes and helpers for the 64-bit integer ALU.
`default_nettype none
package ialu_pkg;

    localparam int unsigned XLEN = 64;
    localparam int unsigned HALF = XLEN / 2;
    localparam int unsigned DIV_FIRST = 2;
    localparam int unsigned LAST = DIV_FIRST + XLEN - 1;

    typedef enum logic [4:0] {
        CMD_ADD  = 5'd0,
        CMD_SUB  = 5'd1,
        CMD_MUL  = 5'd2,
        CMD_DIV  = 5'd3,
        CMD_MOD  = 5'd4,
        CMD_AND  = 5'd5,
        CMD_OR   = 5'd6,
        CMD_XOR  = 5'd7,
        CMD_SHL  = 5'd8,
        CMD_SAR  = 5'd9,
        CMD_EQ   = 5'd10,
        CMD_NE   = 5'd11,
        CMD_SLT  = 5'd12,
        CMD_SLE  = 5'd13,
        CMD_SGT  = 5'd14,
        CMD_SGE  = 5'd15,
        CMD_ULT  = 5'd16,
        CMD_ULE  = 5'd17,
        CMD_UGT  = 5'd18,
        CMD_UGE  = 5'd19
    } cmd_t;

    typedef struct packed {
        logic            vld;
        cmd_t            cmd;
        logic [XLEN-1:0] res;
        logic [XLEN-1:0] pll;
        logic [HALF-1:0] plh;
        logic [HALF-1:0] phl;
        logic [XLEN-1:0] rem;
        logic [XLEN-1:0] quo;
        logic [XLEN-1:0] mb;
        logic            qneg;
        logic            rneg;
        logic            dz;
    } stage_t;

    // One restoring divide step: one quotient bit.
    function automatic logic [2*XLEN-1:0] div_step(
        input logic [XLEN-1:0] rem,
        input logic [XLEN-1:0] quo,
        input logic [XLEN-1:0] mb
    );
        logic [XLEN:0]   t;
        logic [XLEN:0]   d;
        logic            bitq;
        logic [XLEN-1:0] rn;
        t = {rem, quo[XLEN-1]};
        d = t - {1'b0, mb};
        bitq = (t >= {1'b0, mb});
        rn = bitq ? d[XLEN-1:0] : t[XLEN-1:0];
        return {rn, quo[XLEN-2:0], bitq};
    endfunction

endpackage
`default_nettype wire

[sv/integer_alu_with_compare_top.sv]
// Throughput: one transfer per cycle while no result waits untaken at the output;
// the 64-step divide pipeline sets the depth,
// one quotient bit per stage, and the multiply splits into 32x32 partial products.
// The whole pipeline stalls together while a result waits untaken.
// Reset (rst_n low, asynchronous) clears all valid bits; payload is not reset.
`default_nettype none
`include "integer_alu_with_compare_top_defines.svh"
module integer_alu_with_compare_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_ready,
    input  wire logic [4:0]  command,
    input  wire logic [63:0] operand_a,
    input  wire logic [63:0] operand_b,
    output logic             rsp_valid,
    input  wire logic        rsp_ready,
    output logic [63:0]      value,
    output logic             status
);

    localparam int unsigned W = ialu_pkg::XLEN;
    localparam int unsigned H = ialu_pkg::HALF;
    localparam int unsigned L = ialu_pkg::LAST;

    logic                 adv;
    logic                 in_vld_reg;
    ialu_pkg::cmd_t       in_cmd_reg;
    logic [W-1:0]         in_a_reg;
    logic [W-1:0]         in_b_reg;
    ialu_pkg::stage_t     stg_reg  [1:L];
    ialu_pkg::stage_t     stg_next [1:L];
    logic                 stg_vld_reg [1:L];
    logic                 out_vld_reg;
    ialu_pkg::cmd_t       out_cmd_reg;
    logic [W-1:0]         value_reg;
    logic                 status_reg;
    logic [W-1:0]         value_next;
    logic [W-1:0]         simple_res;
    logic [5:0]           sh;

    assign adv       = !out_vld_reg || rsp_ready;
    assign req_ready = adv;
    assign rsp_valid = out_vld_reg;
    assign value     = value_reg;
    assign status    = status_reg;
    assign sh        = in_b_reg[5:0];

    always_comb
    begin
        case (in_cmd_reg)
            ialu_pkg::CMD_ADD: simple_res = in_a_reg + in_b_reg;
            ialu_pkg::CMD_SUB: simple_res = in_a_reg - in_b_reg;
            ialu_pkg::CMD_AND: simple_res = in_a_reg & in_b_reg;
            ialu_pkg::CMD_OR:  simple_res = in_a_reg | in_b_reg;
            ialu_pkg::CMD_XOR: simple_res = in_a_reg ^ in_b_reg;
            ialu_pkg::CMD_SHL: simple_res = in_a_reg << sh;
            ialu_pkg::CMD_SAR: simple_res = W'($signed(in_a_reg) >>> sh);
            ialu_pkg::CMD_EQ:  simple_res = W'(in_a_reg == in_b_reg);
            ialu_pkg::CMD_NE:  simple_res = W'(in_a_reg != in_b_reg);
            ialu_pkg::CMD_SLT: simple_res = W'($signed(in_a_reg) < $signed(in_b_reg));
            ialu_pkg::CMD_SLE: simple_res = W'($signed(in_a_reg) <= $signed(in_b_reg));
            ialu_pkg::CMD_SGT: simple_res = W'($signed(in_a_reg) > $signed(in_b_reg));
            ialu_pkg::CMD_SGE: simple_res = W'($signed(in_a_reg) >= $signed(in_b_reg));
            ialu_pkg::CMD_ULT: simple_res = W'(in_a_reg < in_b_reg);
            ialu_pkg::CMD_ULE: simple_res = W'(in_a_reg <= in_b_reg);
            ialu_pkg::CMD_UGT: simple_res = W'(in_a_reg > in_b_reg);
            ialu_pkg::CMD_UGE: simple_res = W'(in_a_reg >= in_b_reg);
            default:           simple_res = '0;
        endcase
    end

    always_comb
    begin
        logic [2*W-1:0] st;
        logic [W-1:0]   pfull;
        logic [H-1:0]   pl;
        logic [H-1:0]   ph;
        // setup stage: partial products, magnitudes, signs
        stg_next[1].vld  = in_vld_reg;
        stg_next[1].cmd  = in_cmd_reg;
        stg_next[1].res  = simple_res;
        stg_next[1].pll  = W'(in_a_reg[H-1:0] * in_b_reg[H-1:0]);
        pfull            = W'(in_a_reg[H-1:0] * in_b_reg[W-1:H]);
        pl               = pfull[H-1:0];
        stg_next[1].plh  = pl;
        pfull            = W'(in_a_reg[W-1:H] * in_b_reg[H-1:0]);
        ph               = pfull[H-1:0];
        stg_next[1].phl  = ph;
        stg_next[1].rem  = '0;
        stg_next[1].quo  = in_a_reg[W-1] ? (~in_a_reg + W'(1)) : in_a_reg;
        stg_next[1].mb   = in_b_reg[W-1] ? (~in_b_reg + W'(1)) : in_b_reg;
        stg_next[1].qneg = in_a_reg[W-1] ^ in_b_reg[W-1];
        stg_next[1].rneg = in_a_reg[W-1];
        stg_next[1].dz   = (in_b_reg == '0);
        // divide stages, one quotient bit each
        for (int k = 2; k <= L; k++)
        begin
            stg_next[k] = stg_reg[k-1];
            stg_next[k].vld = stg_vld_reg[k-1];
            st = ialu_pkg::div_step(stg_reg[k-1].rem, stg_reg[k-1].quo, stg_reg[k-1].mb);
            stg_next[k].rem = st[2*W-1:W];
            stg_next[k].quo = st[W-1:0];
        end
        if (stg_reg[1].cmd == ialu_pkg::CMD_MUL)
        begin
            stg_next[2].res = stg_reg[1].pll + {stg_reg[1].plh + stg_reg[1].phl, {H{1'b0}}};
        end
    end

    always_comb
    begin
        case (stg_reg[L].cmd)
            ialu_pkg::CMD_DIV:
                value_next = stg_reg[L].dz ? '0 :
                             (stg_reg[L].qneg ? (~stg_reg[L].quo + W'(1)) : stg_reg[L].quo);
            ialu_pkg::CMD_MOD:
                value_next = stg_reg[L].dz ? '0 :
                             (stg_reg[L].rneg ? (~stg_reg[L].rem + W'(1)) : stg_reg[L].rem);
            default:
                value_next = stg_reg[L].res;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            for (int k = 1; k <= L; k++)
            begin
                stg_vld_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            in_vld_reg  <= req_valid;
            out_vld_reg <= stg_vld_reg[L];
            for (int k = 1; k <= L; k++)
            begin
                stg_vld_reg[k] <= stg_next[k].vld;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            in_cmd_reg  <= ialu_pkg::cmd_t'(command);
            in_a_reg    <= operand_a;
            in_b_reg    <= operand_b;
            out_cmd_reg <= stg_reg[L].cmd;
            value_reg   <= value_next;
            status_reg  <= stg_reg[L].dz &&
                           (stg_reg[L].cmd == ialu_pkg::CMD_DIV ||
                            stg_reg[L].cmd == ialu_pkg::CMD_MOD);
            for (int k = 1; k <= L; k++)
            begin
                stg_reg[k] <= stg_next[k];
            end
        end
    end

    `IALU_ASSERT_NOW(a_dz_zero, rsp_valid && status, value == '0,
        "divide by zero result not zero")
    `IALU_ASSERT_NOW(a_dz_cmd, rsp_valid && status,
        out_cmd_reg == ialu_pkg::CMD_DIV || out_cmd_reg == ialu_pkg::CMD_MOD,
        "status set on non-divide command")
    `IALU_ASSERT_NOW(a_cmp_bool,
        rsp_valid && out_cmd_reg >= ialu_pkg::CMD_EQ && out_cmd_reg <= ialu_pkg::CMD_UGE,
        value[W-1:1] == '0, "compare result not 0 or 1")
    `IALU_ASSERT_NEXT(a_stall_hold, out_vld_reg && !rsp_ready,
        $stable(value_reg) && $stable(stg_vld_reg[L]), "pipeline moved during stall")

endmodule
`default_nettype wire

[sim/tb_integer_alu_with_compare_top.sv]
// Testbench for the 64-bit integer ALU: directed and random commands checked against a predictor.
`timescale 1ns / 100ps
`default_nettype none
module tb_integer_alu_with_compare_top;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 80;

    typedef struct packed {
        logic [63:0] value;
        logic        status;
    } alu_result_t;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_ready;
    logic [4:0]  command;
    logic [63:0] operand_a;
    logic [63:0] operand_b;
    logic        rsp_valid;
    logic        rsp_ready;
    logic [63:0] value;
    logic        status;

    alu_result_t expected_results[$];
    int          error_count;
    int          idle_count;
    bit          stall_free;

    integer_alu_with_compare_top uut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .command(command),
        .operand_a(operand_a),
        .operand_b(operand_b),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .value(value),
        .status(status)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic logic [63:0] abs64(input logic [63:0] x);
        return x[63] ? -x : x;
    endfunction

    function automatic alu_result_t alu_predict(input logic [4:0] cmd,
                                                input logic [63:0] a,
                                                input logic [63:0] b);
        alu_result_t r;
        logic [63:0] mq;
        logic signed [63:0] sa;
        logic signed [63:0] sb;
        sa = a;
        sb = b;
        r = '0;
        case (cmd)
            ialu_pkg::CMD_ADD: r.value = a + b;
            ialu_pkg::CMD_SUB: r.value = a - b;
            ialu_pkg::CMD_MUL: r.value = a * b;
            ialu_pkg::CMD_DIV, ialu_pkg::CMD_MOD:
            begin
                if (b == 64'd0)
                    r.status = 1'b1;
                else if (cmd == ialu_pkg::CMD_DIV)
                begin
                    mq = abs64(a) / abs64(b);
                    r.value = (a[63] ^ b[63]) ? -mq : mq;
                end
                else
                begin
                    mq = abs64(a) % abs64(b);
                    r.value = a[63] ? -mq : mq;
                end
            end
            ialu_pkg::CMD_AND: r.value = a & b;
            ialu_pkg::CMD_OR:  r.value = a | b;
            ialu_pkg::CMD_XOR: r.value = a ^ b;
            ialu_pkg::CMD_SHL: r.value = a << b[5:0];
            ialu_pkg::CMD_SAR: r.value = sa >>> b[5:0];
            ialu_pkg::CMD_EQ:  r.value = 64'(a == b);
            ialu_pkg::CMD_NE:  r.value = 64'(a != b);
            ialu_pkg::CMD_SLT: r.value = 64'(sa < sb);
            ialu_pkg::CMD_SLE: r.value = 64'(sa <= sb);
            ialu_pkg::CMD_SGT: r.value = 64'(sa > sb);
            ialu_pkg::CMD_SGE: r.value = 64'(sa >= sb);
            ialu_pkg::CMD_ULT: r.value = 64'(a < b);
            ialu_pkg::CMD_ULE: r.value = 64'(a <= b);
            ialu_pkg::CMD_UGT: r.value = 64'(a > b);
            ialu_pkg::CMD_UGE: r.value = 64'(a >= b);
            default: r = '0;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic send_command(input logic [4:0] cmd, input logic [63:0] a,
                                input logic [63:0] b);
        int gap;
        gap = stall_free ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        command <= cmd;
        operand_a <= a;
        operand_b <= b;
        expected_results.push_back(alu_predict(cmd, a, b));
        @(posedge clk);
        while (!req_ready) @(posedge clk);
    endtask

    task automatic finish_sending();
        req_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && req_valid && req_ready || rst_n && rsp_valid && rsp_ready)
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Result checker with random back-pressure.
    initial
    begin
        alu_result_t exp_r;
        int stall;
        rsp_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_valid && rsp_ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch($sformatf("unexpected transfer value=%h", value));
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (value !== exp_r.value)
                        report_mismatch($sformatf("value %h expected %h", value, exp_r.value));
                    if (status !== exp_r.status)
                        report_mismatch($sformatf("status %b expected %b", status,
                                                  exp_r.status));
                end
            end
            stall = stall_free ? 0 : $urandom_range(0, 4);
            if (stall == 0)
                rsp_ready <= 1'b1;
            else
            begin
                rsp_ready <= 1'b0;
                repeat (stall - 1) @(posedge clk);
                // next check sees ready low at this edge; ready rises afterwards
                @(posedge clk);
                if (rsp_valid && rsp_ready)
                    report_mismatch("transfer while stalled");
                rsp_ready <= 1'b1;
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] interesting64();
        case ($urandom_range(0, 9))
            0: return 64'd0;
            1: return 64'd1;
            2: return '1;
            3: return 64'h8000_0000_0000_0000;
            4: return 64'h7fff_ffff_ffff_ffff;
            5: return 64'($urandom_range(0, 100));
            6: return -64'($urandom_range(1, 100));
            7: return 64'(1) << $urandom_range(0, 63);
            default: return rand64();
        endcase
    endfunction

    task automatic test_directed();
        logic [63:0] mn;
        logic [63:0] mx;
        mn = 64'h8000_0000_0000_0000;
        mx = 64'h7fff_ffff_ffff_ffff;
        send_command(ialu_pkg::CMD_ADD, mx, 64'd1);
        send_command(ialu_pkg::CMD_SUB, mn, 64'd1);
        send_command(ialu_pkg::CMD_MUL, mx, mx);
        send_command(ialu_pkg::CMD_DIV, -64'sd7, 64'd2);
        send_command(ialu_pkg::CMD_MOD, -64'sd7, 64'd2);
        send_command(ialu_pkg::CMD_DIV, mx, 64'd0);
        send_command(ialu_pkg::CMD_MOD, mn, 64'd0);
        send_command(ialu_pkg::CMD_DIV, mn, '1);
        send_command(ialu_pkg::CMD_MOD, mn, '1);
        send_command(ialu_pkg::CMD_AND, '1, 64'h0123_4567_89ab_cdef);
        send_command(ialu_pkg::CMD_OR, mn, 64'd1);
        send_command(ialu_pkg::CMD_XOR, '1, mx);
        send_command(ialu_pkg::CMD_SHL, 64'd1, 64'd127);
        send_command(ialu_pkg::CMD_SAR, mn, 64'hffff_ffff_ffff_ffc1);
        send_command(ialu_pkg::CMD_SAR, mn, 64'd0);
        send_command(ialu_pkg::CMD_EQ, mx, mx);
        send_command(ialu_pkg::CMD_NE, mx, mn);
        send_command(ialu_pkg::CMD_SLT, mn, mx);
        send_command(ialu_pkg::CMD_SLE, mx, mx);
        send_command(ialu_pkg::CMD_SGT, '1, 64'd0);
        send_command(ialu_pkg::CMD_SGE, mn, mn);
        send_command(ialu_pkg::CMD_ULT, mx, mn);
        send_command(ialu_pkg::CMD_ULE, '1, '1);
        send_command(ialu_pkg::CMD_UGT, '1, 64'd0);
        send_command(ialu_pkg::CMD_UGE, 64'd0, 64'd1);
        send_command(5'd31, '1, '1);
    endtask

    task automatic test_random(input int count);
        logic [4:0] cmd;
        for (int i = 0; i < count; i++)
        begin
            if (i % 200 == 100)
                stall_free = 1'b1;
            else if (i % 200 == 150)
                stall_free = 1'b0;
            cmd = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(0, 31))
                                               : 5'($urandom_range(0, 19));
            send_command(cmd, $urandom_range(0, 1) ? rand64() : interesting64(),
                         $urandom_range(0, 1) ? rand64() : interesting64());
        end
    endtask

    initial
    begin
        int drain;
        rst_n = 1'b0;
        req_valid = 1'b0;
        command = '0;
        operand_a = '0;
        operand_b = '0;
        error_count = 0;
        idle_count = 0;
        stall_free = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(1100);
        finish_sending();
        drain = 0;
        while (expected_results.size() != 0)
            @(posedge clk);
        while (drain < DRAIN_CYCLES)
        begin
            @(posedge clk);
            drain++;
        end
        if (error_count == 0 && expected_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire

[filelist.f]
+incdir+sv
sv/ialu_pkg.sv
sv/integer_alu_with_compare_top.sv
sim/tb_integer_alu_with_compare_top.sv
